[hdl/mfte_pkg.sv]
// ----------------------------------------------------------------------------
// mfte_pkg: shared types and constants of the MJPEG frame timestamp extractor
// Marker bytes, timestamp scaling and the entry passed from parser to emitter.
// ----------------------------------------------------------------------------
package mfte_pkg;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_COM    = 8'hFE;
  localparam logic [7:0] STAMP_TAG = 8'h01;

  localparam logic [23:0] NS_PER_HUNDREDTH = 24'd10000000;

  localparam int QUEUE_DEPTH = 4;

  // One classified word from the parser. A start entry carries D8 and
  // expands to the pair FF D8 at the output.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        soi;
    logic        seen;
    logic [31:0] seconds;
    logic [7:0]  hundredths;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/mfte_front.sv]
// ----------------------------------------------------------------------------
// mfte_front: stream parser
// Tracks SOI/EOI and comment markers, captures the timestamp, and pushes one
// classified entry for every byte that belongs to a frame.
// ----------------------------------------------------------------------------
module mfte_front
  import mfte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_data
);

  localparam logic [2:0] M_HUNT       = 3'd0;
  localparam logic [2:0] M_HUNT_FF    = 3'd1;
  localparam logic [2:0] M_BODY       = 3'd2;
  localparam logic [2:0] M_BODY_FF    = 3'd3;
  localparam logic [2:0] M_HEADER     = 3'd4;
  localparam logic [2:0] M_SECONDS    = 3'd5;
  localparam logic [2:0] M_HUNDREDTHS = 3'd6;

  logic [2:0]  mode, mode_next;
  logic [1:0]  cnt, cnt_next;
  logic [31:0] acc, acc_next;
  logic [31:0] held_sec, held_sec_next;
  logic [7:0]  held_hund, held_hund_next;
  logic        held_flag, held_flag_next;
  logic        emit, last, soi;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_next      = mode;
    cnt_next       = cnt;
    acc_next       = acc;
    held_sec_next  = held_sec;
    held_hund_next = held_hund;
    held_flag_next = held_flag;
    emit           = 1'b1;
    last           = 1'b0;
    soi            = 1'b0;
    unique case (mode)
      M_HUNT_FF: begin
        if (stream_byte == MK_SOI) begin
          held_sec_next  = '0;
          held_hund_next = '0;
          held_flag_next = 1'b0;
          acc_next       = '0;
          cnt_next       = '0;
          mode_next      = M_BODY;
          soi            = 1'b1;
        end else begin
          mode_next = M_HUNT;
          emit      = 1'b0;
        end
      end
      M_BODY: begin
        if (stream_byte == MK_PREFIX) mode_next = M_BODY_FF;
      end
      M_BODY_FF: begin
        if (stream_byte == MK_COM) begin
          cnt_next  = '0;
          mode_next = M_HEADER;
        end else if (stream_byte == MK_EOI) begin
          last      = 1'b1;
          mode_next = M_HUNT;
        end else begin
          mode_next = M_BODY;
        end
      end
      M_HEADER: begin
        if (cnt == 2'd3) begin
          cnt_next = '0;
          if (stream_byte == STAMP_TAG) begin
            acc_next  = '0;
            mode_next = M_SECONDS;
          end else begin
            mode_next = M_BODY;
          end
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      M_SECONDS: begin
        acc_next = {acc[23:0], stream_byte};
        if (cnt == 2'd3) begin
          cnt_next  = '0;
          mode_next = M_HUNDREDTHS;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      M_HUNDREDTHS: begin
        held_sec_next  = acc;
        held_hund_next = stream_byte;
        held_flag_next = 1'b1;
        mode_next      = M_BODY;
      end
      default: begin
        // unused codes hunt as well
        mode_next = (stream_byte == MK_PREFIX) ? M_HUNT_FF : M_HUNT;
        emit      = 1'b0;
      end
    endcase
  end

  assign q_push            = accept && emit;
  assign q_data.data       = stream_byte;
  assign q_data.last       = last;
  assign q_data.soi        = soi;
  assign q_data.seen       = held_flag_next;
  assign q_data.seconds    = held_sec_next;
  assign q_data.hundredths = held_hund_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_HUNT;
      cnt       <= '0;
      acc       <= '0;
      held_sec  <= '0;
      held_hund <= '0;
      held_flag <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      cnt       <= cnt_next;
      acc       <= acc_next;
      held_sec  <= held_sec_next;
      held_hund <= held_hund_next;
      held_flag <= held_flag_next;
    end
  end

endmodule

[hdl/mfte_queue.sv]
// ----------------------------------------------------------------------------
// mfte_queue: entry queue
// Small register FIFO that decouples the parser from the output emitter.
// ----------------------------------------------------------------------------
module mfte_queue
  import mfte_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  input  logic   pop,
  output entry_t rdata,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == LAST_PTR) ? '0 : wptr + PTR_W'(1);
      if (pop)  rptr <= (rptr == LAST_PTR) ? '0 : rptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");

endmodule

[hdl/mfte_back.sv]
// ----------------------------------------------------------------------------
// mfte_back: output emitter
// Drains the queue into the output register, expands a start entry into the
// pair FF D8 and scales the hundredths byte to nanoseconds.
// ----------------------------------------------------------------------------
module mfte_back
  import mfte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  entry_t      q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_last,
  output logic        stamp_seen,
  output logic [31:0] stamp_seconds,
  output logic [31:0] stamp_nanoseconds
);

  logic        phase;   // set once the FF of a start pair has gone out
  logic        load;
  logic [31:0] ns_value;

  assign load     = !q_empty && (!out_valid || out_ready);
  assign q_pop    = load && (!q_data.soi || phase);
  assign ns_value = {24'd0, q_data.hundredths} * {8'd0, NS_PER_HUNDREDTH};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= q_data.soi && !phase;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte        <= (q_data.soi && !phase) ? MK_PREFIX : q_data.data;
      frame_last        <= q_data.last;
      stamp_seen        <= q_data.seen;
      stamp_seconds     <= q_data.seconds;
      stamp_nanoseconds <= ns_value;
    end
  end

  a_phase_holds_start: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!q_empty && q_data.soi))
    else $error("start pair split from its queue entry");
  a_start_pops_second: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.soi) |-> phase)
    else $error("start entry dropped before FF was sent");
  a_last_is_eoi: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last) |-> (frame_byte == MK_EOI))
    else $error("last flag on a byte other than D9");
  a_ff_then_d8: assert property (@(posedge clk) disable iff (rst)
    (load && q_data.soi && !phase) |=> (frame_byte == MK_PREFIX && phase))
    else $error("start pair not opened with FF");

endmodule

[hdl/mjpeg_frame_timestamp_extractor.sv]
// ----------------------------------------------------------------------------
// mjpeg_frame_timestamp_extractor: MJPEG frame splitter with timestamp capture
// Cuts JPEG frames out of a camera byte stream and tags them with timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, stream_byte) takes one stream byte per
//   word. Output channel (out_valid/out_ready) gives one frame byte per word
//   with frame_last on the D9 of FF D9 and the timestamp held so far
//   (stamp_seen, stamp_seconds, stamp_nanoseconds).
//   Bytes outside a frame give no word; the D8 of FF D8 gives the two words
//   FF and D8; every byte inside a frame gives one word.
//   Throughput: one byte per cycle in and one word per cycle out while the
//   queue has room and out_ready is high; the entry queue absorbs start pairs.
//   Path: the parser pushes an accepted byte's entry into the queue, and the
//   emitter then registers the queue head into the output register.
//   When the receiver stalls, the output register holds its word and the
//   queue fills; in_ready drops once the queue holds DEPTH entries.
//   Reset puts the parser in hunting with a cleared timestamp and empties
//   the queue and output register.
// ----------------------------------------------------------------------------
module mjpeg_frame_timestamp_extractor
  import mfte_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_last,
  output logic        stamp_seen,
  output logic [31:0] stamp_seconds,
  output logic [31:0] stamp_nanoseconds
);

  entry_t push_data;
  entry_t head_data;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  mfte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .q_full      (full),
    .q_push      (push),
    .q_data      (push_data)
  );

  mfte_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (head_data),
    .full  (full),
    .empty (empty)
  );

  mfte_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_data            (head_data),
    .q_empty           (empty),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .frame_byte        (frame_byte),
    .frame_last        (frame_last),
    .stamp_seen        (stamp_seen),
    .stamp_seconds     (stamp_seconds),
    .stamp_nanoseconds (stamp_nanoseconds)
  );

endmodule
